### design/ecpu_pkg.sv
// Shared types and constants for the Ethernet frame to CAN message unpacker.
package ecpu_pkg;

  localparam int MAX_DATA_BYTES      = 8;
  localparam int DEF_MAX_FRAME_BYTES = 2048;
  localparam int DATA_IDX_W          = $clog2(MAX_DATA_BYTES);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_OFFSET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MAILBOX = 2'd1;

  localparam logic [7:0] COUNT_OFFSET_RST  = 8'd18;
  localparam logic [3:0] START_MAILBOX_RST = 4'd8;
  localparam logic [3:0] DATA_LEN_MAX      = 4'(MAX_DATA_BYTES);

  typedef enum logic [4:0] {
    PH_WAIT_COUNT = 5'b00001,
    PH_HDR0       = 5'b00010,
    PH_HDR1       = 5'b00100,
    PH_DATA       = 5'b01000,
    PH_DONE       = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
  } beat_t;

  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [11:0]                     message_id;
    logic [3:0]                      payload_len;
    logic [MAX_DATA_BYTES-1:0][7:0]  data_bytes;
    logic [3:0]                      mailbox;
    logic                            length_error;
  } msg_t;

endpackage

### design/eth_frame_can_pdu_unpacker.sv
// Top level of the Ethernet frame to CAN message unpacker.
//
// Input channel: one frame byte per beat (in_frame_byte), with in_frame_start
// set on byte 0 of each frame. The byte at count_offset gives the message
// count; each message is two header bytes followed by its data bytes.
// Output channel: one beat per message with identifier, length (saturated at
// eight, length_error set when the header asked for more), eight data bytes
// zero past the length, and the transmit mailbox.
// Config channel: index 0 writes count_offset, index 1 writes start_mailbox,
// which also becomes the mailbox of the next message. cfg_ready is always high.
// Throughput: one byte per cycle while the receiver keeps up. A byte goes into
// an input register, is parsed once the output register is free or draining,
// and its message is loaded into the output register, which raises out_valid.
// When the receiver stalls with a message held, the parser holds; the input
// register keeps its byte (or takes one if empty) and in_ready stays low
// until the message is taken.
// Reset: parsing starts as if a frame had begun, count_offset is 18 and the
// mailbox is 8; no clearing pass is needed.
module eth_frame_can_pdu_unpacker #(
  parameter int MAX_FRAME_BYTES = ecpu_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_frame_byte,
  input  logic                            in_frame_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [11:0]                     out_message_id,
  output logic [3:0]                      out_payload_len,
  output logic [7:0]                      out_data_byte0,
  output logic [7:0]                      out_data_byte1,
  output logic [7:0]                      out_data_byte2,
  output logic [7:0]                      out_data_byte3,
  output logic [7:0]                      out_data_byte4,
  output logic [7:0]                      out_data_byte5,
  output logic [7:0]                      out_data_byte6,
  output logic [7:0]                      out_data_byte7,
  output logic [3:0]                      out_mailbox,
  output logic                            out_length_error,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ecpu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecpu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ecpu_pkg::*;

  beat_t   in_beat, beat;
  logic    beat_valid;
  logic    advance;
  logic    emit;
  msg_t    msg, msg_q;
  cfg_wr_t cfg;

  assign in_beat.frame_byte  = in_frame_byte;
  assign in_beat.frame_start = in_frame_start;

  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // parse only when the output register is free or draining this cycle
  assign advance = beat_valid && (!out_valid || out_ready);

  ecpu_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  ecpu_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .beat  (beat),
    .cfg   (cfg),
    .emit  (emit),
    .msg   (msg)
  );

  ecpu_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && emit),
    .msg_in    (msg),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .msg_out   (msg_q)
  );

  assign out_message_id   = msg_q.message_id;
  assign out_payload_len  = msg_q.payload_len;
  assign out_data_byte0   = msg_q.data_bytes[0];
  assign out_data_byte1   = msg_q.data_bytes[1];
  assign out_data_byte2   = msg_q.data_bytes[2];
  assign out_data_byte3   = msg_q.data_bytes[3];
  assign out_data_byte4   = msg_q.data_bytes[4];
  assign out_data_byte5   = msg_q.data_bytes[5];
  assign out_data_byte6   = msg_q.data_bytes[6];
  assign out_data_byte7   = msg_q.data_bytes[7];
  assign out_mailbox      = msg_q.mailbox;
  assign out_length_error = msg_q.length_error;

endmodule

### design/ecpu_in_stage.sv
// Input register stage: captures one frame byte beat per cycle while not stalled.
module ecpu_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ecpu_pkg::beat_t in_beat,
  input  logic          advance,
  output logic          beat_valid,
  output ecpu_pkg::beat_t beat
);
  import ecpu_pkg::*;

  logic  valid_r, valid_nxt;
  beat_t beat_r;
  logic  accept;

  assign in_ready = !valid_r || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat_r <= in_beat;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

### design/ecpu_parser.sv
// Frame parser: count, header and data phases, mailbox rotation, config registers.
module ecpu_parser #(
  parameter int MAX_FRAME_BYTES = ecpu_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  ecpu_pkg::beat_t   beat,
  input  ecpu_pkg::cfg_wr_t cfg,
  output logic              emit,
  output ecpu_pkg::msg_t    msg
);
  import ecpu_pkg::*;

  localparam int PosW = $clog2(MAX_FRAME_BYTES);
  localparam int CmpW = (PosW > 8) ? PosW : 8;
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_FRAME_BYTES - 1);

  phase_t                         phase_r, phase_nxt, ph;
  logic [PosW-1:0]                pos_r, pos_nxt, pos;
  logic [7:0]                     msgs_r, msgs_nxt;
  logic [7:0]                     hdr0_r, hdr0_nxt;
  logic [7:0]                     hdr1_r, hdr1_nxt;
  logic [3:0]                     left_r, left_nxt;
  logic [3:0]                     idx_r, idx_nxt;
  logic [MAX_DATA_BYTES-1:0][7:0] data_r, data_nxt;
  logic [3:0]                     mbox_r, mbox_nxt;
  logic [7:0]                     cnt_off_r;
  logic [7:0]                     b;
  logic [7:0]                     hdr1_sel;
  logic                           cfg_mbox_wr;

  assign b  = beat.frame_byte;
  assign ph = beat.frame_start ? PH_WAIT_COUNT : phase_r;
  assign pos = beat.frame_start ? '0 : pos_r;

  always_comb begin
    phase_nxt = ph;
    pos_nxt   = pos;
    msgs_nxt  = msgs_r;
    hdr0_nxt  = hdr0_r;
    hdr1_nxt  = hdr1_r;
    left_nxt  = left_r;
    idx_nxt   = idx_r;
    data_nxt  = data_r;
    emit      = 1'b0;
    unique case (ph)
      PH_WAIT_COUNT: begin
        if (CmpW'(pos) == CmpW'(cnt_off_r)) begin
          msgs_nxt  = b;
          phase_nxt = (b == 8'd0) ? PH_DONE : PH_HDR0;
        end
      end
      PH_HDR0: begin
        hdr0_nxt  = b;
        phase_nxt = PH_HDR1;
      end
      PH_HDR1: begin
        hdr1_nxt = b;
        left_nxt = hdr0_r[3:0];
        idx_nxt  = 4'd0;
        data_nxt = '0;
        if (hdr0_r[3:0] == 4'd0) begin
          emit = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        // bytes past the eighth are consumed and dropped
        if (idx_r < DATA_LEN_MAX) begin
          data_nxt[idx_r[DATA_IDX_W-1:0]] = b;
        end
        idx_nxt  = idx_r + 4'd1;
        left_nxt = left_r - 4'd1;
        if (left_nxt == 4'd0) begin
          emit = 1'b1;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    if (emit) begin
      msgs_nxt  = msgs_r - 8'd1;
      phase_nxt = (msgs_nxt == 8'd0) ? PH_DONE : PH_HDR0;
    end
    // stop at the last byte position a frame may hold
    if (pos >= MaxPos) begin
      phase_nxt = PH_DONE;
    end else begin
      pos_nxt = pos + 1'b1;
    end
  end

  assign hdr1_sel = (ph == PH_HDR1) ? b : hdr1_r;

  always_comb begin
    msg.message_id   = {hdr1_sel, hdr0_r[7:4]};
    msg.length_error = hdr0_r[3:0] > DATA_LEN_MAX;
    msg.payload_len  = msg.length_error ? DATA_LEN_MAX : hdr0_r[3:0];
    msg.data_bytes   = data_nxt;
    msg.mailbox      = mbox_r;
  end

  assign cfg_mbox_wr = cfg.wr && (cfg.index == CFG_START_MAILBOX);

  always_comb begin
    mbox_nxt = mbox_r;
    if (cfg_mbox_wr) begin
      mbox_nxt = cfg.data[3:0];
    end else if (step && emit) begin
      mbox_nxt = {1'b1, mbox_r[2:0] + 3'd1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT_COUNT;
      pos_r     <= '0;
      msgs_r    <= '0;
      left_r    <= '0;
      idx_r     <= '0;
      mbox_r    <= START_MAILBOX_RST;
      cnt_off_r <= COUNT_OFFSET_RST;
    end else begin
      mbox_r <= mbox_nxt;
      if (step) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        msgs_r  <= msgs_nxt;
        left_r  <= left_nxt;
        idx_r   <= idx_nxt;
      end
      if (cfg.wr) begin
        unique case (cfg.index)
          CFG_COUNT_OFFSET: cnt_off_r <= cfg.data;
          CFG_START_MAILBOX: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hdr0_r <= hdr0_nxt;
      hdr1_r <= hdr1_nxt;
      data_r <= data_nxt;
    end
  end

  a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (ph == PH_HDR1 || ph == PH_DATA))
    else $error("message emitted outside header or data phase");

  a_mbox_rotate: assert property (@(posedge clk) disable iff (!rst_n)
    (step && emit && !cfg_mbox_wr) |=> mbox_r[3])
    else $error("mailbox left the upper bank after rotation");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MaxPos)
    else $error("byte position ran past frame limit");

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("parse phase lost its one-hot code");

endmodule

### design/ecpu_out_stage.sv
// Output register stage: holds one unpacked message until the receiver takes it.
module ecpu_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  ecpu_pkg::msg_t msg_in,
  input  logic           out_ready,
  output logic           out_valid,
  output ecpu_pkg::msg_t msg_out
);
  import ecpu_pkg::*;

  logic valid_r, valid_nxt;
  msg_t msg_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      msg_r <= msg_in;
    end
  end

  assign out_valid = valid_r;
  assign msg_out   = msg_r;

endmodule
